@@ design/mgmt_frame_probe_dedup_parser_assert.svh @@
// Assertion shorthands used by the parser top-level design file.
`ifndef MGMT_FRAME_PROBE_DEDUP_PARSER_ASSERT_SVH
`define MGMT_FRAME_PROBE_DEDUP_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MFPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MFPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mfpd_pkg.sv @@
package mfpd_pkg;

  localparam int MAC_SLOTS  = 10;
  localparam int SSID_STORE = 24;
  localparam int SSID_MAX   = SSID_STORE - 1;
  localparam int SSID_AW    = (SSID_MAX > 1) ? $clog2(SSID_MAX) : 1;
  localparam int SSID_CW    = $clog2(SSID_MAX + 1);

  localparam int MAC_W = 48;
  localparam int POS_W = 6;

  localparam logic [POS_W-1:0] POS_LIMIT     = 6'd63;
  localparam logic [POS_W-1:0] MAC_LEN       = 6'd6;
  localparam logic [POS_W-1:0] PROBE_MAC_OFF = 6'd10;
  localparam logic [POS_W-1:0] PROBE_EL_OFF  = 6'd24;
  localparam logic [POS_W-1:0] OTHER_MAC_OFF = 6'd16;
  localparam logic [POS_W-1:0] OTHER_EL_OFF  = 6'd36;

  localparam logic [3:0] SUB_PROBE_REQ  = 4'h4;
  localparam logic [3:0] SUB_PROBE_RESP = 4'h5;
  localparam logic [3:0] SUB_BEACON     = 4'h8;

  localparam logic [1:0] KIND_PROBE_REQ  = 2'd0;
  localparam logic [1:0] KIND_PROBE_RESP = 2'd1;
  localparam logic [1:0] KIND_BEACON     = 2'd2;
  localparam logic [1:0] KIND_OTHER      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_EMIT
  } state_t;

  // Search token walking the chain of stored sources.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [MAC_W-1:0] mac;
  } probe_t;

  // Summary of a finished frame.
  typedef struct packed {
    logic               ok;
    logic [1:0]         kind;
    logic [3:0]         channel;
    logic [7:0]         rssi;
    logic [MAC_W-1:0]   mac;
    logic [SSID_CW-1:0] len;
  } snap_t;

endpackage

@@ design/mgmt_frame_probe_dedup_parser.sv @@
// Parses 802.11 frames arriving one byte per request on the slave side (tlast on
// the final byte, management flag in tuser, channel and RSSI taken with the first
// byte) and reports each new management source with its SSID, one result per SSID
// byte or a single result for an empty SSID. Frame bytes are taken at one per
// cycle. After the final byte the input stalls while the frame summary is frozen,
// then, for a management frame that reached its source address, while the search
// token walks the chain of 10 recent-source cells, then for each result an SSID
// store read followed by the output, plus any m_tready stall. Non-management or
// short frames stall the input only while the summary is frozen; duplicates also
// during the search. The recent-source chain resets to all zero, so an all-zero
// source counts as seen until ten new sources have pushed the zeros out.
`include "mgmt_frame_probe_dedup_parser_assert.svh"

module mgmt_frame_probe_dedup_parser import mfpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // frame_byte[7:0], rx_channel[11:8], rx_rssi[19:12], zero
  input  logic        s_tlast,  // frame_end
  input  logic        s_tuser,  // is_mgmt
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // frame_kind[1:0], out_channel[5:2], out_rssi[13:6],
                                // source_mac[61:14], ssid_length[66:62],
                                // ssid_index[71:67], ssid_char[79:72]
  output logic        m_tlast   // last_result
);

  state_t             state;
  state_t             state_next;
  logic [SSID_AW-1:0] k;
  logic [SSID_AW-1:0] k_next;
  logic               inject;
  logic               shift;
  logic               last;
  logic               accept;
  logic               done;
  snap_t              snap;
  logic [7:0]         rd_data;

  logic [MAC_W-1:0]   entries [MAC_SLOTS+1];
  probe_t             chain_p [MAC_SLOTS+1];

  assign accept = s_tvalid && s_tready;

  mfpd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .frame_byte (s_tdata[7:0]),
    .frame_end  (s_tlast),
    .is_mgmt    (s_tuser),
    .rx_channel (s_tdata[11:8]),
    .rx_rssi    (s_tdata[19:12]),
    .rd_addr    (k),
    .rd_data    (rd_data),
    .snap       (snap),
    .done       (done)
  );

  // New sources enter at the head; the oldest drops off the tail.
  assign entries[0]     = snap.mac;
  assign chain_p[0]     = '{valid: inject, hit: 1'b0, mac: snap.mac};

  for (genvar i = 0; i < MAC_SLOTS; i++) begin : g_cell
    mfpd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .entry_in  (entries[i]),
      .entry_out (entries[i+1]),
      .probe_in  (chain_p[i]),
      .probe_out (chain_p[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    inject     = 1'b0;
    shift      = 1'b0;
    m_tvalid   = 1'b0;
    s_tready   = 1'b0;
    last       = (snap.len == '0) || (SSID_CW'(k) + SSID_CW'(1) == snap.len);
    unique case (state)
      S_IDLE: begin
        s_tready = !done;
        k_next   = '0;
        if (done && snap.ok) begin
          inject     = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (chain_p[MAC_SLOTS].valid) begin
          if (chain_p[MAC_SLOTS].hit) begin
            state_next = S_IDLE;
          end else begin
            shift      = 1'b1;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (last) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + SSID_AW'(1);
            state_next = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_tdata[1:0]   = snap.kind;
    m_tdata[5:2]   = snap.channel;
    m_tdata[13:6]  = snap.rssi;
    m_tdata[61:14] = snap.mac;
    m_tdata[66:62] = 5'(snap.len);
    m_tdata[71:67] = (snap.len == '0) ? 5'd0 : 5'(k);
    m_tdata[79:72] = (snap.len == '0) ? 8'd0 : rd_data;
    m_tlast        = last;
  end

  `MFPD_ASSERT_NOW(a_store_only_new, shift, chain_p[MAC_SLOTS].valid && !chain_p[MAC_SLOTS].hit, "source stored without a clean search")
  `MFPD_ASSERT_NOW(a_token_in_search, chain_p[MAC_SLOTS].valid, state == S_SEARCH, "search token left the chain outside a search")
  `MFPD_ASSERT_NOW(a_index_in_range, m_tvalid && snap.len != '0, SSID_CW'(k) < snap.len, "SSID index beyond reported length")
  `MFPD_ASSERT_NEXT(a_last_frees_input, m_tvalid && m_tready && m_tlast, s_tready, "input not released after final result")

endmodule

@@ design/mfpd_cell.sv @@
module mfpd_cell import mfpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [MAC_W-1:0] entry_in,
  output logic [MAC_W-1:0] entry_out,
  input  probe_t           probe_in,
  output probe_t           probe_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_out <= '0;
    end else if (shift) begin
      entry_out <= entry_in;
    end
  end

  // Pass the token on, marking a hit against this slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.mac <= probe_in.mac;
    probe_out.hit <= probe_in.hit | (probe_in.valid && (entry_out == probe_in.mac));
  end

endmodule

@@ design/mfpd_parser.sv @@
module mfpd_parser import mfpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         frame_byte,
  input  logic               frame_end,
  input  logic               is_mgmt,
  input  logic [3:0]         rx_channel,
  input  logic [7:0]         rx_rssi,
  input  logic [SSID_AW-1:0] rd_addr,
  output logic [7:0]         rd_data,
  output snap_t              snap,
  output logic               done
);

  logic [POS_W-1:0]   byte_position;
  logic [3:0]         subtype_code;
  logic [MAC_W-1:0]   mac_assembly;
  logic [8:0]         element_header;
  logic [SSID_CW-1:0] ssid_received;
  logic [12:0]        frame_meta;

  logic [7:0]         ssid_mem [SSID_MAX];

  logic               first;
  logic [3:0]         sub_eff;
  logic [12:0]        meta_eff;
  logic [POS_W-1:0]   mac_off;
  logic [POS_W-1:0]   el_off;
  logic [POS_W-1:0]   ssid_pos;
  logic               ssid_wr;
  logic [MAC_W-1:0]   mac_next;
  logic [8:0]         header_next;
  logic [SSID_CW-1:0] received_next;
  logic [POS_W-1:0]   position_next;
  logic [7:0]         hdr_len;
  logic [SSID_CW-1:0] len;
  logic [1:0]         kind;

  always_comb begin
    first    = (byte_position == '0);
    sub_eff  = first ? frame_byte[7:4] : subtype_code;
    meta_eff = first ? {is_mgmt, rx_channel, rx_rssi} : frame_meta;
    if (sub_eff == SUB_PROBE_REQ) begin
      mac_off = PROBE_MAC_OFF;
      el_off  = PROBE_EL_OFF;
    end else begin
      mac_off = OTHER_MAC_OFF;
      el_off  = OTHER_EL_OFF;
    end

    if (byte_position >= mac_off && byte_position < mac_off + MAC_LEN) begin
      mac_next = {mac_assembly[MAC_W-9:0], frame_byte};
    end else begin
      mac_next = mac_assembly;
    end

    priority if (byte_position == el_off && frame_byte == 8'd0) begin
      header_next = 9'h100;
    end else if (byte_position == el_off + POS_W'(1)) begin
      header_next = {element_header[8], frame_byte};
    end else begin
      header_next = element_header;
    end

    // Take SSID bytes in order only, up to the element length and the store size.
    ssid_pos = byte_position - (el_off + POS_W'(2));
    ssid_wr  = (byte_position >= el_off + POS_W'(2)) && element_header[8]
               && ({2'b00, ssid_pos} < element_header[7:0])
               && (ssid_pos < POS_W'(SSID_MAX))
               && (ssid_pos == POS_W'(ssid_received));
    received_next = ssid_wr ? SSID_CW'(ssid_pos + POS_W'(1)) : ssid_received;

    position_next = (byte_position == POS_LIMIT) ? byte_position
                                                 : byte_position + POS_W'(1);

    hdr_len = header_next[8] ? header_next[7:0] : 8'd0;
    len     = (hdr_len < 8'(received_next)) ? SSID_CW'(hdr_len) : received_next;

    unique case (sub_eff)
      SUB_PROBE_REQ:  kind = KIND_PROBE_REQ;
      SUB_PROBE_RESP: kind = KIND_PROBE_RESP;
      SUB_BEACON:     kind = KIND_BEACON;
      default:        kind = KIND_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      subtype_code   <= '0;
      mac_assembly   <= '0;
      element_header <= '0;
      ssid_received  <= '0;
      frame_meta     <= '0;
      done           <= 1'b0;
    end else begin
      done <= accept && frame_end;
      if (accept && frame_end) begin
        byte_position  <= '0;
        subtype_code   <= '0;
        mac_assembly   <= '0;
        element_header <= '0;
        ssid_received  <= '0;
        frame_meta     <= '0;
      end else if (accept) begin
        byte_position  <= position_next;
        subtype_code   <= sub_eff;
        mac_assembly   <= mac_next;
        element_header <= header_next;
        ssid_received  <= received_next;
        frame_meta     <= meta_eff;
      end
    end
  end

  // Freeze the frame summary on its final byte.
  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      snap.ok      <= meta_eff[12] && (byte_position >= mac_off + POS_W'(5));
      snap.kind    <= kind;
      snap.channel <= meta_eff[11:8];
      snap.rssi    <= meta_eff[7:0];
      snap.mac     <= mac_next;
      snap.len     <= len;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ssid_wr) begin
      ssid_mem[ssid_pos[SSID_AW-1:0]] <= frame_byte;
    end
    rd_data <= ssid_mem[rd_addr];
  end

endmodule
